>>> hw/rtl/lpc_pkg.sv
// ----------------------------------------------------------------------------
// Layer priority pixel compositor package
// Shared payload types, configuration layout and layer codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lpc_pkg;

	localparam int COLOR_W    = 15;
	localparam int CHAN_W     = 5;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [CHAN_W-1:0] CHAN_MASK = 5'h1f;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] REG_BG_MODE    = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_MODE1_HIGH = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_BRIGHTNESS = 2'd2;

	// Background modes.
	localparam logic [2:0] MODE_0 = 3'd0;
	localparam logic [2:0] MODE_1 = 3'd1;
	localparam logic [2:0] MODE_2 = 3'd2;
	localparam logic [2:0] MODE_3 = 3'd3;
	localparam logic [2:0] MODE_4 = 3'd4;
	localparam logic [2:0] MODE_5 = 3'd5;
	localparam logic [2:0] MODE_6 = 3'd6;

	localparam logic [2:0] RESET_BG_MODE    = MODE_0;
	localparam logic       RESET_MODE1_HIGH = 1'b0;
	localparam logic [3:0] RESET_BRIGHTNESS = 4'd15;

	// Layer chosen by the priority logic.
	localparam logic [2:0] PICK_BG1  = 3'd0;
	localparam logic [2:0] PICK_BG2  = 3'd1;
	localparam logic [2:0] PICK_BG3  = 3'd2;
	localparam logic [2:0] PICK_BG4  = 3'd3;
	localparam logic [2:0] PICK_OBJ  = 3'd4;
	localparam logic [2:0] PICK_NONE = 3'd5;

	typedef struct packed {
		logic [COLOR_W-1:0] bg1_color;
		logic [COLOR_W-1:0] bg2_color;
		logic [COLOR_W-1:0] bg3_color;
		logic [COLOR_W-1:0] bg4_color;
		logic [COLOR_W-1:0] obj_color;
		logic [4:0]         opaque_mask;
		logic [3:0]         bg_high_prio;
		logic [1:0]         obj_prio;
	} pix_t;

	typedef struct packed {
		logic [COLOR_W-1:0] out_color;
		logic               is_backdrop;
	} res_t;

	typedef struct packed {
		logic [2:0] bg_mode;
		logic       mode1_bg3_high;
		logic [3:0] brightness;
	} cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/lpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Compositor configuration registers
// Write-only register file for mode, mode 1 option and brightness.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [lpc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  wire logic [lpc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output lpc_pkg::cfg_t                          cfg
);

	lpc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bg_mode        <= lpc_pkg::RESET_BG_MODE;
			cfg_q.mode1_bg3_high <= lpc_pkg::RESET_MODE1_HIGH;
			cfg_q.brightness     <= lpc_pkg::RESET_BRIGHTNESS;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				lpc_pkg::REG_BG_MODE:    cfg_q.bg_mode        <= cfg_wdata[2:0];
				lpc_pkg::REG_MODE1_HIGH: cfg_q.mode1_bg3_high <= cfg_wdata[0];
				lpc_pkg::REG_BRIGHTNESS: cfg_q.brightness     <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> hw/rtl/lpc_select.sv
// ----------------------------------------------------------------------------
// Compositor layer select
// Picks the front opaque layer for the mode and applies the brightness mask.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_select (
	input  wire lpc_pkg::pix_t pix,
	input  wire lpc_pkg::cfg_t cfg,
	output lpc_pkg::res_t      res
);

	logic [3:0] bgh;
	logic [3:0] bgl;
	logic [3:0] obj;
	logic [2:0] pick;
	logic [lpc_pkg::COLOR_W-1:0] color;
	logic [lpc_pkg::CHAN_W-1:0]  mask;

	// Opaque high, opaque low, and opaque sprite at each level.
	assign bgh = pix.opaque_mask[3:0] & pix.bg_high_prio;
	assign bgl = pix.opaque_mask[3:0] & ~pix.bg_high_prio;
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			obj[k] = pix.opaque_mask[4] && (pix.obj_prio == 2'(k));
		end
	end

	always_comb begin
		pick = lpc_pkg::PICK_NONE;
		unique case (cfg.bg_mode) inside
			lpc_pkg::MODE_0: begin
				if      (obj[3]) pick = lpc_pkg::PICK_OBJ;
				else if (bgh[0]) pick = lpc_pkg::PICK_BG1;
				else if (bgh[1]) pick = lpc_pkg::PICK_BG2;
				else if (obj[2]) pick = lpc_pkg::PICK_OBJ;
				else if (bgl[0]) pick = lpc_pkg::PICK_BG1;
				else if (bgl[1]) pick = lpc_pkg::PICK_BG2;
				else if (obj[1]) pick = lpc_pkg::PICK_OBJ;
				else if (bgh[2]) pick = lpc_pkg::PICK_BG3;
				else if (bgh[3]) pick = lpc_pkg::PICK_BG4;
				else if (obj[0]) pick = lpc_pkg::PICK_OBJ;
				else if (bgl[2]) pick = lpc_pkg::PICK_BG3;
				else if (bgl[3]) pick = lpc_pkg::PICK_BG4;
			end
			lpc_pkg::MODE_1: begin
				if      (bgh[2] && cfg.mode1_bg3_high)  pick = lpc_pkg::PICK_BG3;
				else if (obj[3])                        pick = lpc_pkg::PICK_OBJ;
				else if (bgh[0])                        pick = lpc_pkg::PICK_BG1;
				else if (bgh[1])                        pick = lpc_pkg::PICK_BG2;
				else if (obj[2])                        pick = lpc_pkg::PICK_OBJ;
				else if (bgl[0])                        pick = lpc_pkg::PICK_BG1;
				else if (bgl[1])                        pick = lpc_pkg::PICK_BG2;
				else if (obj[1])                        pick = lpc_pkg::PICK_OBJ;
				else if (bgh[2] && !cfg.mode1_bg3_high) pick = lpc_pkg::PICK_BG3;
				else if (obj[0])                        pick = lpc_pkg::PICK_OBJ;
				else if (bgl[2])                        pick = lpc_pkg::PICK_BG3;
			end
			lpc_pkg::MODE_2, lpc_pkg::MODE_3, lpc_pkg::MODE_4, lpc_pkg::MODE_5: begin
				if      (bgh[0]) pick = lpc_pkg::PICK_BG1;
				else if (bgh[1]) pick = lpc_pkg::PICK_BG2;
				else if (bgl[0]) pick = lpc_pkg::PICK_BG1;
				else if (bgl[1]) pick = lpc_pkg::PICK_BG2;
			end
			lpc_pkg::MODE_6: begin
				if (pix.opaque_mask[0]) pick = lpc_pkg::PICK_BG1;
			end
			default: begin
				// Mode 7 has no layer order and always shows the backdrop.
				pick = lpc_pkg::PICK_NONE;
			end
		endcase
	end

	always_comb begin
		case (pick)
			lpc_pkg::PICK_BG1: color = pix.bg1_color;
			lpc_pkg::PICK_BG2: color = pix.bg2_color;
			lpc_pkg::PICK_BG3: color = pix.bg3_color;
			lpc_pkg::PICK_BG4: color = pix.bg4_color;
			lpc_pkg::PICK_OBJ: color = pix.obj_color;
			default:           color = '0;
		endcase
	end

	assign mask = {cfg.brightness, cfg.brightness[0]} & lpc_pkg::CHAN_MASK;

	assign res.out_color   = color & {mask, mask, mask};
	assign res.is_backdrop = (pick == lpc_pkg::PICK_NONE);

endmodule

`default_nettype wire

>>> hw/rtl/layer_priority_pixel_compositor_top.sv
// ----------------------------------------------------------------------------
// Layer priority pixel compositor
// Chooses the front opaque layer of one pixel position and dims it.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request is held in the input register, passes the
// select logic and is loaded into the result register, which drives res; a
// stalled result side holds it there. Throughput: one request per cycle
// while the result side is not stalled.
// Reset: arst_n clears both stage valid flags and loads the configuration
// defaults (mode 0, mode 1 option off, brightness 15).
`default_nettype none

module layer_priority_pixel_compositor_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Pixel request channel.
	input  wire logic                           pix_valid,
	output logic                                pix_ready,
	input  wire lpc_pkg::pix_t                  pix,
	// Composited result channel.
	output logic                                res_valid,
	input  wire logic                           res_ready,
	output lpc_pkg::res_t                       res,
	// Configuration write port.
	input  wire logic                           cfg_we,
	input  wire logic [lpc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [lpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	lpc_pkg::cfg_t cfg;
	lpc_pkg::pix_t pix_s1;
	logic          valid_s1;
	lpc_pkg::res_t res_comb;
	lpc_pkg::res_t res_s2;
	logic          valid_s2;
	logic          load_s2;
	logic          move_s1;

	// The user must write configuration only while the pipeline is empty, so
	// the select logic can read the live register values. The block does not enforce it.
	lpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// The result register may take a new value when it is empty or when its
	// current result is being taken this cycle.
	assign load_s2   = !valid_s2 || res_ready;
	assign move_s1   = valid_s1 && load_s2;
	// The input register frees up whenever its content moves forward, so a
	// new request enters while an older result still waits downstream.
	assign pix_ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_ready) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_valid && pix_ready) begin
			pix_s1 <= pix;
		end
	end

	// Priority select and brightness mask sit between the two registers.
	lpc_select u_select (
		.pix (pix_s1),
		.cfg (cfg),
		.res (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

endmodule

`default_nettype wire

>>> hw/rtl/lpc_checker.sv
// ----------------------------------------------------------------------------
// Compositor port checker
// Concurrent checks on the compositor ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           pix_valid,
	input wire logic                           pix_ready,
	input wire lpc_pkg::pix_t                  pix,
	input wire logic                           res_valid,
	input wire logic                           res_ready,
	input wire lpc_pkg::res_t                  res,
	input wire logic                           cfg_we,
	input wire logic [lpc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input wire logic [lpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	logic [3:0] bright_q;

	// Shadow of the brightness register as seen on the write port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= lpc_pkg::RESET_BRIGHTNESS;
		end else if (cfg_we && (cfg_addr == lpc_pkg::REG_BRIGHTNESS)) begin
			bright_q <= cfg_wdata;
		end
	end

	// A stalled result holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("stalled result changed or dropped");

	// The backdrop always carries color zero.
	a_backdrop_black: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.is_backdrop |-> res.out_color == '0)
		else $error("backdrop result with nonzero color");

	// An empty result register never blocks new requests.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> pix_ready)
		else $error("request blocked while result side is empty");

	// A taken request is followed by a result on offer at the output.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready |=> ##1 res_valid)
		else $error("no result two cycles after a request");

	// Zero brightness blanks every color.
	a_dark_blank: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (bright_q == 4'd0) |-> res.out_color == '0)
		else $error("color passed at zero brightness");

endmodule

bind layer_priority_pixel_compositor_top lpc_checker u_lpc_checker (.*);

`default_nettype wire
